// ===== sv/ttg_pkg.sv =====
// ----------------------------------------------------------------------------
// ttg_pkg: shared types and constants for the tap tempo gate generator
// Payload structs, command/mode/register codes and counter sizing.
// ----------------------------------------------------------------------------
package ttg_pkg;

  // counter width of phase, period, low point and tap interval
  localparam int unsigned CW = 32;
  localparam logic [CW-1:0] CNT_LIMIT = {CW{1'b1}};

  localparam int unsigned LED_W   = 16;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // knob scale: period * delta / 2048, split at bit 11
  localparam int unsigned KNOB_SHIFT = 11;
  localparam int unsigned HI_W   = CW - KNOB_SHIFT;
  localparam int unsigned MUL_AW = (HI_W > KNOB_SHIFT) ? HI_W : KNOB_SHIFT;
  localparam int unsigned PROD_W = MUL_AW + SPEED_W;
  localparam int unsigned MAG_W  = CW + 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_TAP   = 2'd1;
  localparam logic [1:0] CMD_SPEED = 2'd2;
  localparam logic [1:0] CMD_MODE  = 2'd3;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;  // no meaning, ignored

  localparam logic [CFG_IDX_W-1:0] REG_TAP_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEADBAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_TOP        = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic               tap_level;
    logic [SPEED_W-1:0] speed_value;
    logic [1:0]         mode_value;
  } in_item_t;

  typedef struct packed {
    logic             gate_out;
    logic [LED_W-1:0] led_level;
  } out_item_t;

endpackage

// ===== sv/tap_tempo_gate_generator_top.sv =====
// ----------------------------------------------------------------------------
// tap_tempo_gate_generator_top: tap tempo gate and LED level generator
// Sequenced datapath around one shared add/compare unit and one multiplier.
// ----------------------------------------------------------------------------
// Order: tap, mode and quiet ticks load the result; a knob rescale first runs
//   MUL_HI, MUL_LO, SUM, APPLY; a ramp tick first divides out 16 quotient bits.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is loaded into the output register, which holds it until taken.
// Reset (rst_ni low, async): registers to their defaults, period half scale,
//   gate low, mode off, output register empty.
module tap_tempo_gate_generator_top
  import ttg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV    = 7'b0000010,  // LED level divide, shift+add per quotient bit
    ST_MUL_HI = 7'b0000100,  // (period >> 11) * delta
    ST_MUL_LO = 7'b0001000,  // (period & 2047) * delta
    ST_SUM    = 7'b0010000,  // magnitude of the period change
    ST_APPLY  = 7'b0100000,  // grow/shrink, saturate, clamp
    ST_FINISH = 7'b1000000   // load the output register
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0]        tap_thr_q, tap_thr_d;
  logic [SPEED_W-1:0] deadband_q, deadband_d;
  logic [LED_W-1:0]   led_top_q, led_top_d;

  // architectural state
  logic [CW-1:0]      phase_q, phase_d;
  logic [CW-1:0]      period_q, period_d;
  logic [CW-1:0]      low_pt_q, low_pt_d;
  logic [CW-1:0]      since_q, since_d;
  logic               gate_q, gate_d;
  logic [1:0]         mode_q, mode_d;
  logic [SPEED_W-1:0] last_spd_q, last_spd_d;
  logic [LED_W-1:0]   led_q, led_d;

  // divider working set
  logic [CW-1:0]      div_r_q, div_r_d;
  logic [CW:0]        div_c_q, div_c_d;
  logic [CW-1:0]      div_b_q, div_b_d;
  logic [LED_W-1:0]   quo_q, quo_d;
  logic [3:0]         bit_q, bit_d;
  logic               sub_q, sub_d;

  // knob working set
  logic [SPEED_W-1:0] kdelta_q, kdelta_d;
  logic               kgrow_q, kgrow_d;
  logic [SPEED_W-1:0] kspd_q, kspd_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [SPEED_W-1:0] mag_lo_q, mag_lo_d;

  // output register
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  // shared divide unit
  logic [CW:0]        div_t;
  logic [CW+1:0]      div_diff;
  logic               div_ge;
  logic [CW-1:0]      div_r_nxt;

  // multiplier
  logic [MUL_AW-1:0]  mul_a;
  logic [PROD_W-1:0]  prod;

  // accept-time helpers
  logic               in_acc;
  logic [CW-1:0]      phase_inc;
  logic [SPEED_W-1:0] spd_delta;
  logic               spd_grow;
  logic [CW+2:0]      grow_sum;
  logic [CW-1:0]      np;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // restoring step: sub 0 shifts the remainder, sub 1 adds b when the
  // dividend bit is set; both then subtract c once if it fits
  always_comb begin
    if (sub_q) begin
      div_t = {1'b0, div_r_q} + (led_top_q[bit_q] ? {1'b0, div_b_q} : '0);
    end else begin
      div_t = {div_r_q, 1'b0};
    end
    div_diff  = {1'b0, div_t} - {1'b0, div_c_q};
    div_ge    = !div_diff[CW+1];
    div_r_nxt = div_ge ? div_diff[CW-1:0] : div_t[CW-1:0];
  end

  // one multiplier, high or low slice of the period against the knob delta
  always_comb begin
    if (state_q == ST_MUL_HI) begin
      mul_a = MUL_AW'(period_q[CW-1:KNOB_SHIFT]);
    end else begin
      mul_a = MUL_AW'(period_q[KNOB_SHIFT-1:0]);
    end
    prod = PROD_W'(mul_a) * PROD_W'(kdelta_q);
  end

  assign phase_inc = phase_q + 1'b1;
  assign spd_grow  = last_spd_q > in_item_i.speed_value;
  assign spd_delta = spd_grow ? (last_spd_q - in_item_i.speed_value)
                              : (in_item_i.speed_value - last_spd_q);

  // new period after a knob move
  always_comb begin
    grow_sum = (CW+3)'(period_q) + (CW+3)'(mag_q);
    if (kgrow_q) begin
      np = (grow_sum > (CW+3)'(CNT_LIMIT)) ? CNT_LIMIT : grow_sum[CW-1:0];
    end else if (mag_q >= MAG_W'(period_q)) begin
      np = '0;
    end else begin
      np = period_q - mag_q[CW-1:0];
    end
    if (np == '0) begin
      np = CW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    tap_thr_d   = tap_thr_q;
    deadband_d  = deadband_q;
    led_top_d   = led_top_q;
    phase_d     = phase_q;
    period_d    = period_q;
    low_pt_d    = low_pt_q;
    since_d     = since_q;
    gate_d      = gate_q;
    mode_d      = mode_q;
    last_spd_d  = last_spd_q;
    led_d       = led_q;
    div_r_d     = div_r_q;
    div_c_d     = div_c_q;
    div_b_d     = div_b_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    sub_d       = sub_q;
    kdelta_d    = kdelta_q;
    kgrow_d     = kgrow_q;
    kspd_d      = kspd_q;
    mag_d       = mag_q;
    mag_lo_d    = mag_lo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    // config writes must only arrive while idle; the block does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_THRESHOLD:  tap_thr_d  = cfg_data_i;
        REG_SPEED_DEADBAND: deadband_d = cfg_data_i[SPEED_W-1:0];
        REG_LED_TOP:        led_top_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_FINISH;
          case (in_item_i.command)
            CMD_TICK: begin
              if (since_q != CNT_LIMIT) begin
                since_d = since_q + 1'b1;
              end
              if (mode_q == MODE_OFF) begin
                phase_d = '0;
              end else if (phase_inc >= period_q) begin
                gate_d  = 1'b1;
                led_d   = led_top_q;
                phase_d = '0;
              end else if (phase_inc >= low_pt_q && gate_q) begin
                gate_d  = 1'b0;
                led_d   = '0;
                phase_d = phase_inc;
              end else begin
                // LED ramp: full scale * b / (period + 1)
                phase_d = phase_inc;
                div_b_d = (mode_q == MODE_UP) ? (period_q - phase_inc) : phase_inc;
                div_c_d = {1'b0, period_q} + 1'b1;
                div_r_d = '0;
                quo_d   = '0;
                bit_d   = 4'd15;
                sub_d   = 1'b0;
                state_d = ST_DIV;
              end
            end
            CMD_TAP: begin
              if (since_q < CW'(tap_thr_q)) begin
                // too early, ignored
              end else if (since_q != CNT_LIMIT) begin
                if (in_item_i.tap_level) begin
                  gate_d   = 1'b1;
                  led_d    = led_top_q;
                  period_d = since_q;
                  low_pt_d = since_q >> 1;
                  phase_d  = '0;
                  since_d  = '0;
                end else begin
                  gate_d = 1'b0;
                  led_d  = '0;
                end
              end else if (in_item_i.tap_level) begin
                // saturated interval: only restart measuring
                since_d = '0;
              end
            end
            CMD_SPEED: begin
              if (spd_delta > deadband_q) begin
                kdelta_d = spd_delta;
                kgrow_d  = spd_grow;
                kspd_d   = in_item_i.speed_value;
                state_d  = ST_MUL_HI;
              end
            end
            CMD_MODE: begin
              if (in_item_i.mode_value != MODE_RSVD) begin
                if (in_item_i.mode_value != mode_q && in_item_i.mode_value == MODE_OFF) begin
                  phase_d = '0;
                  gate_d  = 1'b0;
                  led_d   = '0;
                end
                mode_d = in_item_i.mode_value;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        div_r_d = div_r_nxt;
        sub_d   = !sub_q;
        if (sub_q) begin
          quo_d = quo_q + LED_W'(div_ge);
          if (bit_q == 4'd0) begin
            led_d   = quo_q + LED_W'(div_ge);
            state_d = ST_FINISH;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end else begin
          quo_d = {quo_q[LED_W-2:0], div_ge};
        end
      end
      ST_MUL_HI: begin
        mag_d   = MAG_W'(prod);
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mag_lo_d = prod[KNOB_SHIFT+SPEED_W-1:KNOB_SHIFT];
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        mag_d   = mag_q + MAG_W'(mag_lo_q);
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        period_d   = np;
        low_pt_d   = np >> 1;
        last_spd_d = kspd_q;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_item_d.gate_out  = gate_q;
          out_item_d.led_level = led_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_thr_q   <= 16'd256;
      deadband_q  <= SPEED_W'(16);
      led_top_q   <= LED_W'(4095);
      phase_q     <= '0;
      period_q    <= CNT_LIMIT >> 1;
      low_pt_q    <= CNT_LIMIT >> 2;
      since_q     <= '0;
      gate_q      <= 1'b0;
      mode_q      <= MODE_OFF;
      last_spd_q  <= SPEED_W'(4095);
      led_q       <= '0;
      bit_q       <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_thr_q   <= tap_thr_d;
      deadband_q  <= deadband_d;
      led_top_q   <= led_top_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      low_pt_q    <= low_pt_d;
      since_q     <= since_d;
      gate_q      <= gate_d;
      mode_q      <= mode_d;
      last_spd_q  <= last_spd_d;
      led_q       <= led_d;
      bit_q       <= bit_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    div_r_q    <= div_r_d;
    div_c_q    <= div_c_d;
    div_b_q    <= div_b_d;
    quo_q      <= quo_d;
    kdelta_q   <= kdelta_d;
    kgrow_q    <= kgrow_d;
    kspd_q     <= kspd_d;
    mag_q      <= mag_d;
    mag_lo_q   <= mag_lo_d;
    out_item_q <= out_item_d;
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for tap_tempo_gate_generator_top
// Drives ticks, tap edges, knob samples and mode changes under random idling.
// Each item is run through a local model of the gate generator and every
// result is checked in order against it. Several register settings are
// used, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import ttg_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000; // cycles with no item moving
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
  localparam int TAIL_CYCLES    = 40;   // longest item latency plus margin

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_item_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_item_o;

  tap_tempo_gate_generator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Gate generator model: state and register copies
  // --------------------------------------------------------------------------
  logic [CW-1:0]      phase_q;     // ticks since last gate rise
  logic [CW-1:0]      period_q;    // gate period in ticks
  logic [CW-1:0]      low_pt_q;    // gate falls at or past this phase
  logic [CW-1:0]      tap_gap_q;   // ticks since last accepted tap
  logic               gate_q;
  logic [1:0]         mode_q;
  logic [SPEED_W-1:0] knob_last_q;
  logic [LED_W-1:0]   led_q;

  logic [15:0]        tap_thr_q;
  logic [SPEED_W-1:0] deadband_q;
  logic [LED_W-1:0]   led_top_q;

  out_item_t pending_levels[$]; // expected gate/LED results, oldest first

  int err_cnt;
  int items_sent;
  int results_seen;
  int gate_rises;
  int settings_cnt;
  int cmd_cnt[4];
  int idle_pct;   // sender gap odds, percent
  int stall_pct;  // receiver stall odds, percent
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  // LED ramp: floor(full scale * num / (period + 1)) with no wrap anywhere
  function automatic logic [LED_W-1:0] led_ramp(logic [CW-1:0] num);
    logic [63:0] prod;
    logic [63:0] den;
    prod = 64'(led_top_q) * 64'(num);
    den  = 64'(period_q) + 64'd1;
    prod = prod / den;
    return prod[LED_W-1:0];
  endfunction

  // Advance the model by one item and return the gate/LED result it yields.
  function automatic out_item_t gate_after(in_item_t it);
    logic [SPEED_W-1:0] delta;
    logic [63:0]        mag;
    logic [63:0]        np;
    logic               grow;
    out_item_t          res;
    cmd_cnt[it.command]++;
    case (it.command)
      CMD_TICK: begin
        if (tap_gap_q != CNT_LIMIT) tap_gap_q = tap_gap_q + 1'b1;
        if (mode_q == MODE_OFF) begin
          phase_q = '0;
        end else begin
          phase_q = phase_q + 1'b1;
          if (phase_q >= period_q) begin
            gate_q = 1'b1;
            led_q = led_top_q;
            phase_q = '0;
            gate_rises++;
          end else if (phase_q >= low_pt_q && gate_q) begin
            gate_q = 1'b0;
            led_q = '0;
          end else if (mode_q == MODE_UP) begin
            led_q = led_ramp(period_q - phase_q); // falling level
          end else begin
            led_q = led_ramp(phase_q);            // rising level
          end
        end
      end
      CMD_TAP: begin
        // early taps fall through untouched
        if (tap_gap_q >= CW'(tap_thr_q)) begin
          if (tap_gap_q != CNT_LIMIT) begin
            if (it.tap_level) begin
              gate_q = 1'b1;
              led_q = led_top_q;
              period_q = tap_gap_q;
              low_pt_q = tap_gap_q >> 1;
              phase_q = '0;
              tap_gap_q = '0;
              gate_rises++;
            end else begin
              gate_q = 1'b0;
              led_q = '0;
            end
          end else if (it.tap_level) begin
            tap_gap_q = '0; // saturated interval: restart measuring only
          end
        end
      end
      CMD_SPEED: begin
        grow = knob_last_q > it.speed_value;
        delta = grow ? knob_last_q - it.speed_value : it.speed_value - knob_last_q;
        if (delta > deadband_q) begin
          mag = (64'(period_q) >> KNOB_SHIFT) * 64'(delta)
              + (((64'(period_q) & ((64'd1 << KNOB_SHIFT) - 1)) * 64'(delta)) >> KNOB_SHIFT);
          if (grow) begin
            np = (mag > 64'(CNT_LIMIT) - 64'(period_q)) ? 64'(CNT_LIMIT)
                                                        : 64'(period_q) + mag;
          end else begin
            np = (mag >= 64'(period_q)) ? 64'd0 : 64'(period_q) - mag;
          end
          if (np == 64'd0) np = 64'd1;
          period_q = np[CW-1:0];
          low_pt_q = period_q >> 1;
          knob_last_q = it.speed_value;
        end
      end
      default: begin
        // mode value three is ignored
        if (it.mode_value != MODE_RSVD) begin
          if (it.mode_value != mode_q && it.mode_value == MODE_OFF) begin
            phase_q = '0;
            gate_q = 1'b0;
            led_q = '0;
          end
          mode_q = it.mode_value;
        end
      end
    endcase
    res.gate_out  = gate_q;
    res.led_level = led_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        $error("result with nothing expected: gate_out %0d led_level %0d",
               out_item_o.gate_out, out_item_o.led_level);
        err_cnt++;
      end else begin
        want = pending_levels.pop_front();
        if (out_item_o.gate_out !== want.gate_out) begin
          $error("gate_out mismatch: expected %0d, got %0d",
                 want.gate_out, out_item_o.gate_out);
          err_cnt++;
        end
        if (out_item_o.led_level !== want.led_level) begin
          $error("led_level mismatch: expected %0d, got %0d",
                 want.led_level, out_item_o.led_level);
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when no item moves on either side for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no item moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_levels.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, optionally after a random gap; returns once it is taken.
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_levels.push_back(gate_after(it));
    items_sent++;
  endtask

  // Unused fields carry random bits; the block must ignore them.
  task automatic send_cmd(logic [1:0] cmd, logic lvl, logic [SPEED_W-1:0] spd,
                          logic [1:0] md);
    logic [31:0] r;
    in_item_t    it;
    r = $urandom;
    it = r[$bits(in_item_t)-1:0];
    it.command = cmd;
    case (cmd)
      CMD_TAP:   it.tap_level   = lvl;
      CMD_SPEED: it.speed_value = spd;
      CMD_MODE:  it.mode_value  = md;
      default: ;
    endcase
    send_item(it);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Block must be idle. Writes all three registers back to back.
  task automatic write_config(logic [15:0] thr, logic [SPEED_W-1:0] db,
                              logic [LED_W-1:0] full);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TAP_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SPEED_DEADBAND;
    cfg_data_i <= CFG_W'(db);
    @(posedge clk_i);
    cfg_idx_i  <= REG_LED_TOP;
    cfg_data_i <= full;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tap_thr_q  = thr;
    deadband_q = db;
    led_top_q  = full;
    settings_cnt++;
  endtask

  // Mostly well-formed tempo traffic: tick bursts between taps so the
  // threshold is met, knob moves near and far, occasional mode flips, noise.
  task automatic run_tempo(int n);
    int stop;
    int r;
    int burst;
    int s;
    int delta;
    logic [1:0] md;
    stop = items_sent + n;
    send_cmd(CMD_MODE, 1'b0, '0, $urandom_range(0, 1) ? MODE_UP : MODE_DOWN);
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        burst = $urandom_range(1, (tap_thr_q < 40) ? int'(tap_thr_q) + 8 : 48);
        repeat (burst) send_cmd(CMD_TICK, 1'b0, '0, '0);
      end else if (r < 68) begin
        send_cmd(CMD_TAP, 1'b1, '0, '0);
        if ($urandom_range(0, 1)) send_cmd(CMD_TAP, 1'b0, '0, '0);
      end else if (r < 76) begin
        send_cmd(CMD_TAP, 1'($urandom_range(0, 1)), '0, '0);
      end else if (r < 88) begin
        if ($urandom_range(0, 1)) begin
          s = $urandom_range(0, 4095);
        end else begin
          // near the last knob value, straddling the deadband
          delta = $urandom_range(0, int'(deadband_q) + 8);
          s = int'(knob_last_q) + ($urandom_range(0, 1) ? delta : -delta);
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
        end
        send_cmd(CMD_SPEED, 1'b0, SPEED_W'(s), '0);
      end else if (r < 96) begin
        r = $urandom_range(0, 99);
        md = (r < 40) ? MODE_UP : (r < 80) ? MODE_DOWN : (r < 92) ? MODE_OFF : MODE_RSVD;
        send_cmd(CMD_MODE, 1'b0, '0, md);
      end else begin
        send_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 SPEED_W'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked items: early tap, ignored mode, deadband edge, period
  // saturation and clamp, entering off, zero period, both LED ramps.
  task automatic test_directed();
    send_cmd(CMD_TICK,  1'b0, '0, '0);          // tick while off
    send_cmd(CMD_TAP,   1'b1, '0, '0);          // early tap, ignored
    send_cmd(CMD_MODE,  1'b0, '0, MODE_RSVD);   // undefined mode, ignored
    send_cmd(CMD_MODE,  1'b0, '0, MODE_UP);
    send_cmd(CMD_TICK,  1'b0, '0, '0);          // falling LED, huge period
    send_cmd(CMD_SPEED, 1'b0, 12'd4095, '0);    // no knob movement
    send_cmd(CMD_SPEED, 1'b0, 12'd4079, '0);    // right at the deadband
    send_cmd(CMD_SPEED, 1'b0, 12'd0, '0);       // full grow: saturates
    send_cmd(CMD_TICK,  1'b0, '0, '0);
    send_cmd(CMD_MODE,  1'b0, '0, MODE_DOWN);
    send_cmd(CMD_TICK,  1'b0, '0, '0);          // rising LED
    send_cmd(CMD_MODE,  1'b0, '0, MODE_OFF);    // entering off
    send_cmd(CMD_TICK,  1'b0, '0, '0);
    drain();
    write_config(16'd0, 12'd0, 16'hFFFF);
    send_cmd(CMD_TAP,   1'b1, '0, '0);          // accepted: period from ticks
    send_cmd(CMD_TAP,   1'b0, '0, '0);          // accepted release
    send_cmd(CMD_TAP,   1'b1, '0, '0);          // zero period
    send_cmd(CMD_MODE,  1'b0, '0, MODE_UP);
    send_cmd(CMD_TICK,  1'b0, '0, '0);
    send_cmd(CMD_SPEED, 1'b0, 12'd4095, '0);    // full shrink: clamps to 1
    send_cmd(CMD_SPEED, 1'b0, 12'd0, '0);
    repeat (3) send_cmd(CMD_TICK, 1'b0, '0, '0);
    send_cmd(CMD_MODE,  1'b0, '0, MODE_DOWN);
    send_cmd(CMD_MODE,  1'b0, '0, MODE_DOWN);   // same mode again
    drain();
  endtask

  // Tempo traffic under a series of register settings, extremes included.
  task automatic test_tempo_sweep();
    write_config(16'd8, 12'd16, 16'd4095);
    run_tempo(190);
    write_config(16'd0, 12'd0, 16'hFFFF);
    run_tempo(190);
    write_config(16'd3, 12'd4095, 16'd0);       // knob never rescales
    run_tempo(190);
    write_config(16'hFFFF, 12'd2047, 16'd1);    // taps never accepted
    run_tempo(190);
    write_config(16'($urandom_range(1, 30)), 12'($urandom_range(0, 200)),
                 16'($urandom));
    run_tempo(190);
  endtask

  // A long stretch with neither side idling.
  task automatic test_no_idle();
    idle_pct = 0;
    stall_pct = 0;
    write_config(16'($urandom_range(0, 20)), 12'($urandom_range(0, 64)),
                 16'($urandom));
    run_tempo(140);
    idle_pct = 13;
    stall_pct = 13;
  endtask

  // Receiver holds off while the sender keeps offering, so the block
  // backs up and stalls its input.
  task automatic test_output_hold();
    write_config(16'd4, 12'd8, 16'd1000);
    idle_pct = 0;
    hold_requests++;
    run_tempo(40);
    idle_pct = 13;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    // model at reset
    phase_q     = '0;
    period_q    = CNT_LIMIT >> 1;
    low_pt_q    = CNT_LIMIT >> 2;
    tap_gap_q   = '0;
    gate_q      = 1'b0;
    mode_q      = MODE_OFF;
    knob_last_q = '1;
    led_q       = '0;
    tap_thr_q   = 16'd256;
    deadband_q  = 12'd16;
    led_top_q   = 16'd4095;
    err_cnt = 0;
    items_sent = 0;
    results_seen = 0;
    gate_rises = 0;
    settings_cnt = 0;
    cmd_cnt = '{default: 0};
    idle_pct = 13;
    stall_pct = 13;
    hold_requests = 0;
    quiet_cycles = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_tempo_sweep();
    test_no_idle();
    test_output_hold();

    // catch any stray result after the last expected one
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_levels.size() != 0) begin
      $error("%0d expected results never arrived", pending_levels.size());
      err_cnt++;
    end

    $display("Covered %0d items: %0d ticks, %0d tap edges, %0d knob samples, %0d mode changes",
             items_sent, cmd_cnt[CMD_TICK], cmd_cnt[CMD_TAP], cmd_cnt[CMD_SPEED],
             cmd_cnt[CMD_MODE]);
    $display("Checked %0d results over %0d register settings, %0d gate rises",
             results_seen, settings_cnt, gate_rises);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ttg_pkg.sv
sv/tap_tempo_gate_generator_top.sv
verif/tb.sv
